@@ hw/rtl/tlq_pkg.sv @@
// shared types, widths and helpers for the thick line quad expander
// used by every rtl file of the block
`default_nettype none
package tlq_pkg;

    localparam int CW    = 24;
    localparam int WW    = 16;
    localparam int DW    = CW + 1;
    localparam int RW    = CW + 1;
    localparam int SQW   = 2 * RW;
    localparam int REMW  = RW + 3;
    localparam int PW    = CW + WW;
    localparam int NW    = PW + 1;
    localparam int DENW  = RW + 1;
    localparam int QW    = WW;
    localparam int SUMW  = ((CW > QW + 1) ? CW : QW + 1) + 1;
    localparam int LAT   = RW + QW + 4;

    typedef struct packed {
        logic signed [CW-1:0] start_x;
        logic signed [CW-1:0] start_y;
        logic signed [CW-1:0] end_x;
        logic signed [CW-1:0] end_y;
        logic [WW-1:0]        line_width;
        logic [31:0]          paint_color;
        logic [31:0]          depth_value;
    } in_word_t;

    typedef struct packed {
        logic signed [CW-1:0] start_left_x;
        logic signed [CW-1:0] start_left_y;
        logic signed [CW-1:0] end_left_x;
        logic signed [CW-1:0] end_left_y;
        logic signed [CW-1:0] end_right_x;
        logic signed [CW-1:0] end_right_y;
        logic signed [CW-1:0] start_right_x;
        logic signed [CW-1:0] start_right_y;
        logic [31:0]          out_color;
        logic [31:0]          out_depth;
    } out_word_t;

    typedef struct packed {
        logic signed [CW-1:0] x1;
        logic signed [CW-1:0] y1;
        logic signed [CW-1:0] x2;
        logic signed [CW-1:0] y2;
        logic [31:0]          color;
        logic [31:0]          depth;
        logic                 neg_dx;
        logic                 neg_dy;
    } side_t;

    localparam logic signed [SUMW-1:0] SMAX = SUMW'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [SUMW-1:0] SMIN = -SMAX - SUMW'(1);

    function automatic logic signed [CW-1:0] sat(input logic signed [SUMW-1:0] v);
        logic signed [CW-1:0] r;
        if (v > SMAX)
            r = SMAX[CW-1:0];
        else if (v < SMIN)
            r = SMIN[CW-1:0];
        else
            r = v[CW-1:0];
        return r;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/tlq_front.sv @@
// front stages: differences, magnitudes, squared length and width products
// depends on tlq_pkg
`default_nettype none
module tlq_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire tlq_pkg::in_word_t seg,
    output logic                  out_valid,
    output logic [tlq_pkg::SQW-1:0] sum_sq,
    output logic [tlq_pkg::PW-1:0]  prod_x,
    output logic [tlq_pkg::PW-1:0]  prod_y,
    output tlq_pkg::side_t        side
);
    logic signed [tlq_pkg::DW-1:0] dx, dy, adx, ady;
    logic                          v1_reg, v2_reg;
    logic [tlq_pkg::CW-1:0]        ax_reg, ay_reg;
    logic [tlq_pkg::WW-1:0]        w_reg;
    tlq_pkg::side_t                s1_reg, s2_reg;
    logic [2*tlq_pkg::CW-1:0]      sqx, sqy;
    logic [tlq_pkg::SQW-1:0]       sum_reg;
    logic [tlq_pkg::PW-1:0]        px_reg, py_reg;

    assign dx  = tlq_pkg::DW'(seg.end_x) - tlq_pkg::DW'(seg.start_x);
    assign dy  = tlq_pkg::DW'(seg.end_y) - tlq_pkg::DW'(seg.start_y);
    assign adx = dx[tlq_pkg::DW-1] ? -dx : dx;
    assign ady = dy[tlq_pkg::DW-1] ? -dy : dy;
    assign sqx = ax_reg * ax_reg;
    assign sqy = ay_reg * ay_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid && !(dx == '0 && dy == '0);
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg        <= adx[tlq_pkg::CW-1:0];
        ay_reg        <= ady[tlq_pkg::CW-1:0];
        w_reg         <= seg.line_width;
        s1_reg.x1     <= seg.start_x;
        s1_reg.y1     <= seg.start_y;
        s1_reg.x2     <= seg.end_x;
        s1_reg.y2     <= seg.end_y;
        s1_reg.color  <= seg.paint_color;
        s1_reg.depth  <= seg.depth_value;
        s1_reg.neg_dx <= dx[tlq_pkg::DW-1];
        s1_reg.neg_dy <= dy[tlq_pkg::DW-1];
        sum_reg       <= {2'b00, sqx} + {2'b00, sqy};
        px_reg        <= ay_reg * w_reg;
        py_reg        <= ax_reg * w_reg;
        s2_reg        <= s1_reg;
    end

    assign out_valid = v2_reg;
    assign sum_sq    = sum_reg;
    assign prod_x    = px_reg;
    assign prod_y    = py_reg;
    assign side      = s2_reg;
endmodule
`default_nettype wire

@@ hw/rtl/tlq_isqrt.sv @@
// pipelined integer square root, one root bit per stage
// depends on tlq_pkg
`default_nettype none
module tlq_isqrt (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic [tlq_pkg::SQW-1:0] sum_sq,
    input  wire logic [tlq_pkg::PW-1:0]  prod_x_in,
    input  wire logic [tlq_pkg::PW-1:0]  prod_y_in,
    input  wire tlq_pkg::side_t     side_in,
    output logic                    out_valid,
    output logic [tlq_pkg::RW-1:0]  root,
    output logic [tlq_pkg::PW-1:0]  prod_x,
    output logic [tlq_pkg::PW-1:0]  prod_y,
    output tlq_pkg::side_t          side
);
    localparam int RW = tlq_pkg::RW;

    logic                         v_reg    [0:RW];
    logic [tlq_pkg::SQW-1:0]      s_reg    [0:RW];
    logic [tlq_pkg::REMW-1:0]     rem_reg  [0:RW];
    logic [RW-1:0]                root_reg [0:RW];
    logic [tlq_pkg::PW-1:0]       px_reg   [0:RW];
    logic [tlq_pkg::PW-1:0]       py_reg   [0:RW];
    tlq_pkg::side_t               sd_reg   [0:RW];

    assign v_reg[0]    = in_valid;
    assign s_reg[0]    = sum_sq;
    assign rem_reg[0]  = '0;
    assign root_reg[0] = '0;
    assign px_reg[0]   = prod_x_in;
    assign py_reg[0]   = prod_y_in;
    assign sd_reg[0]   = side_in;

    for (genvar i = 0; i < RW; i++)
    begin : g_stage
        logic [tlq_pkg::REMW-1:0] rem2, trial;
        assign rem2  = {rem_reg[i][tlq_pkg::REMW-3:0], s_reg[i][tlq_pkg::SQW-1 -: 2]};
        assign trial = {1'b0, root_reg[i], 2'b01};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else
                v_reg[i+1] <= v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            s_reg[i+1]  <= {s_reg[i][tlq_pkg::SQW-3:0], 2'b00};
            px_reg[i+1] <= px_reg[i];
            py_reg[i+1] <= py_reg[i];
            sd_reg[i+1] <= sd_reg[i];
            if (rem2 >= trial)
            begin
                rem_reg[i+1]  <= rem2 - trial;
                root_reg[i+1] <= {root_reg[i][RW-2:0], 1'b1};
            end
            else
            begin
                rem_reg[i+1]  <= rem2;
                root_reg[i+1] <= {root_reg[i][RW-2:0], 1'b0};
            end
        end
    end

    assign out_valid = v_reg[RW];
    assign root      = root_reg[RW];
    assign prod_x    = px_reg[RW];
    assign prod_y    = py_reg[RW];
    assign side      = sd_reg[RW];
endmodule
`default_nettype wire

@@ hw/rtl/tlq_div.sv @@
// pipelined restoring divider for both offsets, one quotient bit per stage
// depends on tlq_pkg
`default_nettype none
module tlq_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic [tlq_pkg::RW-1:0] root,
    input  wire logic [tlq_pkg::PW-1:0] prod_x,
    input  wire logic [tlq_pkg::PW-1:0] prod_y,
    input  wire tlq_pkg::side_t     side_in,
    output logic                    out_valid,
    output logic [tlq_pkg::QW-1:0]  quot_x,
    output logic [tlq_pkg::QW-1:0]  quot_y,
    output tlq_pkg::side_t          side
);
    localparam int QW = tlq_pkg::QW;
    localparam int NW = tlq_pkg::NW;

    logic                       v_reg   [0:QW];
    logic [NW-1:0]              rx_reg  [0:QW];
    logic [NW-1:0]              ry_reg  [0:QW];
    logic [tlq_pkg::DENW-1:0]   den_reg [0:QW];
    logic [QW-1:0]              qx_reg  [0:QW];
    logic [QW-1:0]              qy_reg  [0:QW];
    tlq_pkg::side_t             sd_reg  [0:QW];

    // numerator carries the rounding term
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        rx_reg[0]  <= NW'(prod_x) + NW'(root);
        ry_reg[0]  <= NW'(prod_y) + NW'(root);
        den_reg[0] <= {root, 1'b0};
        qx_reg[0]  <= '0;
        qy_reg[0]  <= '0;
        sd_reg[0]  <= side_in;
    end

    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        localparam int B = QW - 1 - i;
        logic [NW-1:0] dsh;
        assign dsh = NW'(den_reg[i]) << B;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else
                v_reg[i+1] <= v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            den_reg[i+1] <= den_reg[i];
            sd_reg[i+1]  <= sd_reg[i];
            if (rx_reg[i] >= dsh)
            begin
                rx_reg[i+1] <= rx_reg[i] - dsh;
                qx_reg[i+1] <= qx_reg[i] | (QW'(1) << B);
            end
            else
            begin
                rx_reg[i+1] <= rx_reg[i];
                qx_reg[i+1] <= qx_reg[i];
            end
            if (ry_reg[i] >= dsh)
            begin
                ry_reg[i+1] <= ry_reg[i] - dsh;
                qy_reg[i+1] <= qy_reg[i] | (QW'(1) << B);
            end
            else
            begin
                ry_reg[i+1] <= ry_reg[i];
                qy_reg[i+1] <= qy_reg[i];
            end
        end
    end

    assign out_valid = v_reg[QW];
    assign quot_x    = qx_reg[QW];
    assign quot_y    = qy_reg[QW];
    assign side      = sd_reg[QW];
endmodule
`default_nettype wire

@@ hw/rtl/tlq_corner.sv @@
// final stage: signed offsets, corner sums and saturation
// depends on tlq_pkg
`default_nettype none
module tlq_corner (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic [tlq_pkg::QW-1:0] quot_x,
    input  wire logic [tlq_pkg::QW-1:0] quot_y,
    input  wire tlq_pkg::side_t    side,
    output logic                   out_valid,
    output tlq_pkg::out_word_t     quad
);
    localparam int SUMW = tlq_pkg::SUMW;

    logic signed [SUMW-1:0] ox, oy, x1, y1, x2, y2;
    logic                   v_reg;
    tlq_pkg::out_word_t     q_reg;

    assign ox = side.neg_dy ? -SUMW'({1'b0, quot_x}) : SUMW'({1'b0, quot_x});
    assign oy = side.neg_dx ? -SUMW'({1'b0, quot_y}) : SUMW'({1'b0, quot_y});
    assign x1 = SUMW'(side.x1);
    assign y1 = SUMW'(side.y1);
    assign x2 = SUMW'(side.x2);
    assign y2 = SUMW'(side.y2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        q_reg.start_left_x  <= tlq_pkg::sat(x1 - ox);
        q_reg.start_left_y  <= tlq_pkg::sat(y1 + oy);
        q_reg.end_left_x    <= tlq_pkg::sat(x2 - ox);
        q_reg.end_left_y    <= tlq_pkg::sat(y2 + oy);
        q_reg.end_right_x   <= tlq_pkg::sat(x2 + ox);
        q_reg.end_right_y   <= tlq_pkg::sat(y2 - oy);
        q_reg.start_right_x <= tlq_pkg::sat(x1 + ox);
        q_reg.start_right_y <= tlq_pkg::sat(y1 - oy);
        q_reg.out_color     <= side.color;
        q_reg.out_depth     <= side.depth;
    end

    assign out_valid = v_reg;
    assign quad      = q_reg;
endmodule
`default_nettype wire

@@ hw/rtl/thick_line_quad_expander_core.sv @@
// top level of the thick line quad expander
// depends on tlq_pkg, tlq_front, tlq_isqrt, tlq_div, tlq_corner
//
// One segment word is taken every cycle (busy stays low) and its quad comes out on quad with
// done high after passing the front, square root, divider and corner stages in that order; the
// square root and divider pipelines give one bit per stage. The receiver cannot stall.
// A zero-length segment gives no word.
`default_nettype none
module thick_line_quad_expander_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire tlq_pkg::in_word_t seg,
    output logic                   done,
    output tlq_pkg::out_word_t     quad
);
    logic                      f_valid, s_valid, d_valid;
    logic [tlq_pkg::SQW-1:0]   sum_sq;
    logic [tlq_pkg::PW-1:0]    fpx, fpy, spx, spy;
    logic [tlq_pkg::RW-1:0]    root;
    logic [tlq_pkg::QW-1:0]    qx, qy;
    tlq_pkg::side_t            f_side, s_side, d_side;

    assign busy = 1'b0;

    tlq_front u_front (
        .clk, .rst_n, .in_valid(start && !busy), .seg,
        .out_valid(f_valid), .sum_sq, .prod_x(fpx), .prod_y(fpy), .side(f_side)
    );

    tlq_isqrt u_isqrt (
        .clk, .rst_n, .in_valid(f_valid), .sum_sq, .prod_x_in(fpx), .prod_y_in(fpy),
        .side_in(f_side), .out_valid(s_valid), .root, .prod_x(spx), .prod_y(spy),
        .side(s_side)
    );

    tlq_div u_div (
        .clk, .rst_n, .in_valid(s_valid), .root, .prod_x(spx), .prod_y(spy),
        .side_in(s_side), .out_valid(d_valid), .quot_x(qx), .quot_y(qy), .side(d_side)
    );

    tlq_corner u_corner (
        .clk, .rst_n, .in_valid(d_valid), .quot_x(qx), .quot_y(qy), .side(d_side),
        .out_valid(done), .quad
    );
endmodule
`default_nettype wire

@@ hw/rtl/tlq_checker.sv @@
// port-level checks for the thick line quad expander, bound to the top level
// depends on tlq_pkg
`default_nettype none
module tlq_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire tlq_pkg::in_word_t  seg,
    input wire logic               done,
    input wire tlq_pkg::out_word_t quad
);
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, tlq_pkg::LAT))
        else $error("word without a start");

    a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
        $past(start && seg.start_x == seg.end_x && seg.start_y == seg.end_y, tlq_pkg::LAT)
        |-> !done)
        else $error("word for zero-length segment");

    a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (quad.out_color == $past(seg.paint_color, tlq_pkg::LAT)
              && quad.out_depth == $past(seg.depth_value, tlq_pkg::LAT)))
        else $error("color or depth changed");
endmodule

bind thick_line_quad_expander_core tlq_checker u_tlq_checker (.*);
`default_nettype wire
